FILE: src/mlr_pkg.sv
// Shared types and constants for the matrix line rotator.
// No dependencies; compiled before every other file of the block.

package mlr_pkg;

   // Request and result field widths (fixed by the request format)
   localparam int MODE_BITS     = 2;
   localparam int INDEX_BITS    = 3;
   localparam int AMOUNT_BITS   = 8;
   localparam int DATA_BITS     = 32;
   localparam int REG_BITS      = 4;
   localparam int CSR_ADDR_BITS = 2;
   localparam int STEP_BITS     = $clog2(AMOUNT_BITS);

   // Request modes
   localparam logic [MODE_BITS-1:0] MODE_WRITE   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_ROT_ROW = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_ROT_COL = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_READ    = 2'd3;

   // Register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ROWS_USED = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_COLS_USED = 2'd1;

   localparam logic [REG_BITS-1:0] ROWS_USED_RESET = 4'd8;
   localparam logic [REG_BITS-1:0] COLS_USED_RESET = 4'd8;

   // Line length or element count; always fits the register width
   typedef logic [REG_BITS-1:0] len_type;

   // Shift control for the line buffer cells
   typedef struct packed {
      logic step_left;   // take the higher neighbor
      logic step_right;  // take the lower neighbor
   } shift_ctrl_type;

endpackage

FILE: src/mlr_if.sv
// Valid/ready channels of the matrix line rotator: request, result, register write.
// Depends on mlr_pkg for field widths.

interface mlr_req_if import mlr_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [MODE_BITS-1:0]          mode;
   logic [INDEX_BITS-1:0]         line_index;
   logic [INDEX_BITS-1:0]         position;
   logic                          direction;
   logic [AMOUNT_BITS-1:0]        amount;
   logic signed [DATA_BITS-1:0]   value;

   modport source (output valid, mode, line_index, position, direction, amount, value,
                   input ready);
   modport sink (input valid, mode, line_index, position, direction, amount, value,
                 output ready);
endinterface

interface mlr_rsp_if import mlr_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [DATA_BITS-1:0]   data;
   logic [INDEX_BITS-1:0]         element_pos;
   logic                          last;
   logic                          error;

   modport source (output valid, data, element_pos, last, error, input ready);
   modport sink (input valid, data, element_pos, last, error, output ready);
endinterface

interface mlr_csr_if import mlr_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [CSR_ADDR_BITS-1:0]      index;
   logic [REG_BITS-1:0]           wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

FILE: src/mlr_cell.sv
// One word cell of the line buffer chain; shifts toward either neighbor.
// Depends on mlr_pkg for the shift control struct.

module mlr_cell import mlr_pkg::*; #(
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  shift_ctrl_type       ctrl,
   input  logic [WORD_BITS-1:0] from_left,
   input  logic [WORD_BITS-1:0] from_right,
   output logic [WORD_BITS-1:0] q
);

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;

   // Pick the neighbor to take, or hold
   always_comb begin
      word_in = word_ff;
      if (ctrl.step_left) begin
         word_in = from_right;
      end else if (ctrl.step_right) begin
         word_in = from_left;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign q = word_ff;

endmodule

FILE: src/mlr_mod.sv
// Remainder unit: amount modulo line length, one restoring step per cycle.
// Depends on mlr_pkg for widths.

module mlr_mod import mlr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [AMOUNT_BITS-1:0] amount,
   input  len_type                divisor,
   output len_type                rem,
   output logic                   done
);

   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(AMOUNT_BITS - 1);

   logic                   run_ff, run_in;
   logic [STEP_BITS-1:0]   cnt_ff, cnt_in;
   logic [AMOUNT_BITS-1:0] amt_ff, amt_in;
   len_type                rem_ff, rem_in;
   logic [REG_BITS:0]      trial;

   // Bring in the next amount bit, subtract the divisor if it fits
   always_comb begin
      trial  = {rem_ff, amt_ff[AMOUNT_BITS-1]};
      done   = run_ff && (cnt_ff == LAST_STEP);
      run_in = run_ff;
      cnt_in = cnt_ff;
      amt_in = amt_ff;
      rem_in = rem_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         amt_in = amount;
         rem_in = '0;
      end else if (run_ff) begin
         amt_in = amt_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (trial >= {1'b0, divisor}) begin
            rem_in = len_type'(trial - {1'b0, divisor});
         end else begin
            rem_in = len_type'(trial);
         end
         if (done) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      amt_ff <= amt_in;
      rem_ff <= rem_in;
   end

   assign rem = rem_ff;

endmodule

FILE: src/matrix_line_rotator_top.sv
// Channel  | Dir | Handshake     | Payload
// csr_ch   | in  | valid/ready   | index, wdata (rows_used, cols_used)
// req_ch   | in  | valid/ready   | mode, line_index, position, direction, amount, value
// rsp_ch   | out | valid/ready   | data, element_pos, last, error
//
// One request at a time; write and error requests go from idle to the result state,
// reads pass through the read-wait state first, and each result is registered in
// the output register. A rotate runs 8 remainder steps to reduce the amount to k,
// reads the line (len = line length) into the cell chain, shifts it k times, then
// emits len results, each also written back through the single memory port.
// Reset (synchronous, active high) clears control and sets rows/cols used to 8;
// matrix contents stay undefined until written. A stalled result holds in the
// output register; the next request is taken once the sequencer is back to idle.
// Depends on mlr_pkg, mlr_if, mlr_mod and mlr_cell.

module matrix_line_rotator_top import mlr_pkg::*; #(
   parameter int MAX_ROWS  = 8,
   parameter int MAX_COLS  = 8,
   parameter int WORD_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   mlr_csr_if.sink    csr_ch,
   mlr_req_if.sink    req_ch,
   mlr_rsp_if.source  rsp_ch
);

   localparam int DEPTH     = MAX_ROWS * MAX_COLS;
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LINE_MAX  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int IDX_BITS  = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_RDWAIT = 3'd1;
   localparam logic [2:0] ST_RESULT = 3'd2;
   localparam logic [2:0] ST_MOD    = 3'd3;
   localparam logic [2:0] ST_LOAD   = 3'd4;
   localparam logic [2:0] ST_ROT    = 3'd5;
   localparam logic [2:0] ST_DRAIN  = 3'd6;

   function automatic len_type clamp_len(len_type v, int maxv);
      if (v == '0) begin
         return len_type'(1);
      end
      if (int'(v) > maxv) begin
         return len_type'(maxv);
      end
      return v;
   endfunction

   // Control state
   logic [2:0]             state_ff, state_in;
   len_type                rows_used_ff, cols_used_ff;
   len_type                j_ff, j_in;
   len_type                rot_cnt_ff, rot_cnt_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Request context and pending result
   logic                   is_row_ff, is_row_in;
   logic [INDEX_BITS-1:0]  line_ff, line_in;
   logic                   dir_ff, dir_in;
   len_type                len_ff, len_in;
   logic [DATA_BITS-1:0]   pend_data_ff, pend_data_in;
   logic [INDEX_BITS-1:0]  pend_pos_ff, pend_pos_in;
   logic                   pend_error_ff, pend_error_in;

   // Output register
   logic [DATA_BITS-1:0]   rsp_data_ff, rsp_data_in;
   logic [INDEX_BITS-1:0]  rsp_pos_ff, rsp_pos_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_error_ff, rsp_error_in;

   // Matrix memory
   logic [WORD_BITS-1:0]   mem [DEPTH];
   logic [WORD_BITS-1:0]   mem_rdata_ff;
   logic [ADDR_BITS-1:0]   mem_addr;
   logic [WORD_BITS-1:0]   mem_wdata;
   logic                   mem_we;
   len_type                a_row, a_col;

   // Decode and helpers
   len_type                nr, nc, req_len;
   logic                   req_fire, req_err, out_free;
   logic [WORD_BITS-1:0]   wr_word;
   logic                   mod_start, mod_done;
   len_type                mod_rem;

   // Cell chain
   shift_ctrl_type         shift_ctrl;
   logic [WORD_BITS-1:0]   cell_q [LINE_MAX];
   logic [IDX_BITS-1:0]    tail;
   logic [WORD_BITS-1:0]   tail_feed, tail_q;

   // Register writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_used_ff <= ROWS_USED_RESET;
         cols_used_ff <= COLS_USED_RESET;
      end else if (csr_ch.valid) begin
         if (csr_ch.index == CSR_ROWS_USED) begin
            rows_used_ff <= csr_ch.wdata;
         end else if (csr_ch.index == CSR_COLS_USED) begin
            cols_used_ff <= csr_ch.wdata;
         end
      end
   end

   // Decode the incoming request
   assign nr       = clamp_len(rows_used_ff, MAX_ROWS);
   assign nc       = clamp_len(cols_used_ff, MAX_COLS);
   assign req_len  = (req_ch.mode == MODE_ROT_ROW) ? nc : nr;
   assign req_fire = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign wr_word  = WORD_BITS'($signed(req_ch.value));
   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      case (req_ch.mode)
         MODE_ROT_ROW: req_err = ({1'b0, req_ch.line_index} >= nr);
         MODE_ROT_COL: req_err = ({1'b0, req_ch.line_index} >= nc);
         default:      req_err = ({1'b0, req_ch.line_index} >= nr) ||
                                 ({1'b0, req_ch.position} >= nc);
      endcase
   end

   // Memory address: request fields when idle, line walk otherwise
   always_comb begin
      if (state_ff == ST_IDLE) begin
         a_row = len_type'(req_ch.line_index);
         a_col = len_type'(req_ch.position);
      end else if (is_row_ff) begin
         a_row = len_type'(line_ff);
         a_col = j_ff;
      end else begin
         a_row = j_ff;
         a_col = len_type'(line_ff);
      end
      mem_addr = ADDR_BITS'(a_row) * ADDR_BITS'(MAX_COLS) + ADDR_BITS'(a_col);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_addr];
   end

   // Remainder of the rotate amount
   mlr_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (mod_start),
      .amount  (req_ch.amount),
      .divisor (len_ff),
      .rem     (mod_rem),
      .done    (mod_done)
   );

   // Cell chain: loads through the tail, rotates within len cells, drains at cell 0
   assign tail      = IDX_BITS'(len_ff - 1'b1);
   assign tail_q    = cell_q[tail];
   assign tail_feed = (state_ff == ST_LOAD) ? mem_rdata_ff : cell_q[0];

   always_comb begin
      shift_ctrl.step_left  = rd_pend_ff ||
                              ((state_ff == ST_ROT) && (rot_cnt_ff != '0) && dir_ff) ||
                              ((state_ff == ST_DRAIN) && out_free);
      shift_ctrl.step_right = (state_ff == ST_ROT) && (rot_cnt_ff != '0) && !dir_ff;
   end

   for (genvar i = 0; i < LINE_MAX; i++) begin : g_cell
      logic [WORD_BITS-1:0] from_left, from_right;

      if (i == LINE_MAX - 1) begin : g_end
         assign from_right = tail_feed;
      end else begin : g_mid
         assign from_right = (IDX_BITS'(i) == tail) ? tail_feed : cell_q[i+1];
      end

      if (i == 0) begin : g_head
         assign from_left = tail_q;
      end else begin : g_body
         assign from_left = cell_q[i-1];
      end

      mlr_cell #(.WORD_BITS(WORD_BITS)) u_cell (
         .clock      (clock),
         .ctrl       (shift_ctrl),
         .from_left  (from_left),
         .from_right (from_right),
         .q          (cell_q[i])
      );
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      j_in          = j_ff;
      rot_cnt_in    = rot_cnt_ff;
      rd_pend_in    = 1'b0;
      is_row_in     = is_row_ff;
      line_in       = line_ff;
      dir_in        = dir_ff;
      len_in        = len_ff;
      pend_data_in  = pend_data_ff;
      pend_pos_in   = pend_pos_ff;
      pend_error_in = pend_error_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_error_in  = rsp_error_ff;
      mod_start     = 1'b0;
      mem_we        = 1'b0;
      mem_wdata     = cell_q[0];

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               is_row_in     = (req_ch.mode == MODE_ROT_ROW);
               line_in       = req_ch.line_index;
               dir_in        = req_ch.direction;
               len_in        = req_len;
               j_in          = '0;
               pend_pos_in   = req_ch.position;
               pend_error_in = 1'b0;
               pend_data_in  = DATA_BITS'($signed(wr_word));
               if (req_err) begin
                  pend_data_in  = '0;
                  pend_pos_in   = '0;
                  pend_error_in = 1'b1;
                  state_in      = ST_RESULT;
               end else begin
                  case (req_ch.mode)
                     MODE_WRITE: begin
                        mem_we    = 1'b1;
                        mem_wdata = wr_word;
                        state_in  = ST_RESULT;
                     end
                     MODE_READ: begin
                        state_in = ST_RDWAIT;
                     end
                     default: begin
                        mod_start = 1'b1;
                        state_in  = ST_MOD;
                     end
                  endcase
               end
            end
         end
         ST_RDWAIT: begin
            pend_data_in = DATA_BITS'($signed(mem_rdata_ff));
            state_in     = ST_RESULT;
         end
         ST_RESULT: begin
            // Hand the single result to the output register
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_data_ff;
               rsp_pos_in   = pend_pos_ff;
               rsp_last_in  = 1'b1;
               rsp_error_in = pend_error_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // Issue one read per cycle; the data shifts into the chain in the following cycle
            if (j_ff != len_ff) begin
               rd_pend_in = 1'b1;
               j_in       = j_ff + 1'b1;
            end else if (!rd_pend_ff) begin
               rot_cnt_in = mod_rem;
               state_in   = ST_ROT;
            end
         end
         ST_ROT: begin
            if (rot_cnt_ff != '0) begin
               rot_cnt_in = rot_cnt_ff - 1'b1;
            end else begin
               j_in     = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // Emit cell 0 and write it back at its new position
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = DATA_BITS'($signed(cell_q[0]));
               rsp_pos_in   = j_ff[INDEX_BITS-1:0];
               rsp_last_in  = (j_ff == len_ff - 1'b1);
               rsp_error_in = 1'b0;
               mem_we       = 1'b1;
               mem_wdata    = cell_q[0];
               j_in         = j_ff + 1'b1;
               if (j_ff == len_ff - 1'b1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         j_ff         <= '0;
         rot_cnt_ff   <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         j_ff         <= j_in;
         rot_cnt_ff   <= rot_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_row_ff     <= is_row_in;
      line_ff       <= line_in;
      dir_ff        <= dir_in;
      len_ff        <= len_in;
      pend_data_ff  <= pend_data_in;
      pend_pos_ff   <= pend_pos_in;
      pend_error_ff <= pend_error_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_error_ff  <= rsp_error_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.data        = rsp_data_ff;
   assign rsp_ch.element_pos = rsp_pos_ff;
   assign rsp_ch.last        = rsp_last_ff;
   assign rsp_ch.error       = rsp_error_ff;

endmodule

FILE: src/mlr_checker.sv
// Port-level checks for the matrix line rotator, bound to the top level.
// Depends on mlr_pkg and matrix_line_rotator_top.

module mlr_checker import mlr_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [DATA_BITS-1:0] rsp_data,
   input logic [INDEX_BITS-1:0] rsp_element_pos,
   input logic                 rsp_last,
   input logic                 rsp_error
);

   // Hold a stalled result unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) &&
      $stable(rsp_element_pos) && $stable(rsp_last) && $stable(rsp_error))
      else $error("stalled result changed");

   // An error result is a lone, zeroed result
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last && (rsp_data == '0) && (rsp_element_pos == '0))
      else $error("error result not single and zeroed");

   // Take no new request while a rotate is still draining
   a_busy_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken in the middle of a line");

   // Drop any result on reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind matrix_line_rotator_top mlr_checker u_mlr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_data        (rsp_ch.data),
   .rsp_element_pos (rsp_ch.element_pos),
   .rsp_last        (rsp_ch.last),
   .rsp_error       (rsp_ch.error)
);
